>>> design/rlwq_pkg.sv
// Package for the recursive lock with wait queue: sizing constants,
// command and result codes, and the structs passed between modules.
// No dependencies.
package rlwq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int THREAD_COUNT = 256;
	localparam int MAX_HOLD     = 255;

	localparam int TID_W = 8;
	localparam int CNT_W = 8;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MAP_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

	localparam logic [CNT_W-1:0] HOLD_CAP = (MAX_HOLD > 255) ? 8'd255 : CNT_W'(MAX_HOLD);

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_REENTER  = 3'd1,
		ST_QUEUED   = 3'd2,
		ST_DECR     = 3'd3,
		ST_FREED    = 3'd4,
		ST_HANDOFF  = 3'd5,
		ST_NOTHOLD  = 3'd6,
		ST_ERROR    = 3'd7
	} status_t;

	typedef struct packed {
		logic             held;
		logic [TID_W-1:0] owner;
		logic [CNT_W-1:0] count;
	} lock_state_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic             waiting;
		logic [TID_W-1:0] head_tid;
	} queue_stat_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [TID_W-1:0] tid;
	} queue_op_t;

	typedef struct packed {
		status_t          status;
		logic             grant_valid;
		logic [TID_W-1:0] granted_thread;
		logic [CNT_W-1:0] hold_depth;
	} result_t;

endpackage

>>> design/rlwq_queue.sv
// Waiter FIFO with head/tail/count and the per-thread waiting map.
// Depends on rlwq_pkg.
module rlwq_queue import rlwq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  queue_op_t        op,
	input  logic [TID_W-1:0] lookup_tid,
	output queue_stat_t      stat
);

	logic [TID_W-1:0]        fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       head_q;
	logic [QPTR_W-1:0]       tail_q;
	logic [QCNT_W-1:0]       count_q;
	logic [THREAD_COUNT-1:0] map_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (op.push)
			fifo_q[tail_q] <= op.tid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			map_q   <= '0;
		end else if (op.push) begin
			tail_q  <= ptr_next(tail_q);
			count_q <= count_q + 1'b1;
			map_q[op.tid[MAP_W-1:0]] <= 1'b1;
		end else if (op.pop) begin
			head_q  <= ptr_next(head_q);
			count_q <= count_q - 1'b1;
			map_q[fifo_q[head_q][MAP_W-1:0]] <= 1'b0;
		end
	end

	assign stat.full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty    = (count_q == '0);
	assign stat.waiting  = map_q[lookup_tid[MAP_W-1:0]];
	assign stat.head_tid = fifo_q[head_q];

endmodule

>>> design/rlwq_decide.sv
// Per-request decision: next lock state, queue operation and result word.
// Depends on rlwq_pkg.
module rlwq_decide import rlwq_pkg::*; (
	input  command_t         command,
	input  logic [TID_W-1:0] thread_id,
	input  lock_state_t      cur,
	input  queue_stat_t      qstat,
	output lock_state_t      nxt,
	output queue_op_t        qop,
	output result_t          res
);

	logic in_range;
	logic is_holder;

	assign in_range  = ({1'b0, thread_id} < (TID_W + 1)'(THREAD_COUNT));
	assign is_holder = cur.held && (cur.owner == thread_id);

	always_comb begin
		nxt                = cur;
		qop.push           = 1'b0;
		qop.pop            = 1'b0;
		qop.tid            = thread_id;
		res.status         = ST_ERROR;
		res.grant_valid    = 1'b0;
		res.granted_thread = '0;
		if (command == CMD_ACQUIRE) begin
			if (!in_range) begin
				res.status = ST_ERROR;
			end else if (!cur.held) begin
				nxt.held           = 1'b1;
				nxt.owner          = thread_id;
				nxt.count          = CNT_W'(1);
				res.status         = ST_GRANTED;
				res.grant_valid    = 1'b1;
				res.granted_thread = thread_id;
			end else if (is_holder) begin
				if (cur.count >= HOLD_CAP) begin
					res.status = ST_ERROR;
				end else begin
					nxt.count  = cur.count + 1'b1;
					res.status = ST_REENTER;
				end
			end else if (qstat.waiting || qstat.full) begin
				res.status = ST_ERROR;
			end else begin
				qop.push   = 1'b1;
				res.status = ST_QUEUED;
			end
		end else begin
			if (!in_range || !is_holder) begin
				res.status = ST_NOTHOLD;
			end else if (cur.count > CNT_W'(1)) begin
				nxt.count  = cur.count - 1'b1;
				res.status = ST_DECR;
			end else if (!qstat.empty) begin
				qop.pop            = 1'b1;
				nxt.owner          = qstat.head_tid;
				nxt.count          = CNT_W'(1);
				res.status         = ST_HANDOFF;
				res.grant_valid    = 1'b1;
				res.granted_thread = qstat.head_tid;
			end else begin
				nxt.held   = 1'b0;
				nxt.owner  = '0;
				nxt.count  = '0;
				res.status = ST_FREED;
			end
		end
		res.hold_depth = nxt.held ? nxt.count : '0;
	end

endmodule

>>> design/recursive_lock_with_wait_queue_top.sv
// Top level of the recursive lock with FIFO of waiters: input register,
// lock state, decision logic, result register. Depends on rlwq_pkg,
// rlwq_queue and rlwq_decide.
//
//   channel   dir  tdata                          tuser
//   s_axis    in   [7:0] thread_id                [0] command
//   m_axis    out  [7:0] granted_thread,          [2:0] status,
//                  [15:8] hold_depth              [3] grant_valid
//
// One request per cycle sustained while the result is not stalled; a
// request passes the input register, then one pass of decision logic
// that updates lock and queue state and loads the result register.
// Reset clears lock state, queue pointers and the waiting map; FIFO
// slots are not cleared. A stalled result holds the input register,
// which still takes one word while the result waits.
module recursive_lock_with_wait_queue_top import rlwq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] thread_id
	input  logic        s_axis_tuser,   // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] granted_thread, [15:8] hold_depth
	output logic [3:0]  m_axis_tuser    // [2:0] status, [3] grant_valid
);

	logic             valid_s1;
	command_t         command_s1;
	logic [TID_W-1:0] tid_s1;
	logic             out_valid_q;
	result_t          res_q;
	lock_state_t      lock_q;
	lock_state_t      lock_nxt;
	queue_stat_t      qstat;
	queue_op_t        qop;
	queue_op_t        qop_gated;
	result_t          res;
	logic             advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			command_s1 <= command_t'(s_axis_tuser);
			tid_s1     <= s_axis_tdata;
		end
	end

	rlwq_decide u_decide (
		.command   (command_s1),
		.thread_id (tid_s1),
		.cur       (lock_q),
		.qstat     (qstat),
		.nxt       (lock_nxt),
		.qop       (qop),
		.res       (res)
	);

	always_comb begin
		qop_gated      = qop;
		qop_gated.push = qop.push && advance;
		qop_gated.pop  = qop.pop && advance;
	end

	rlwq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (qop_gated),
		.lookup_tid (tid_s1),
		.stat       (qstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				lock_q <= lock_nxt;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.hold_depth, res_q.granted_thread};
	assign m_axis_tuser  = {res_q.grant_valid, res_q.status};

endmodule
